FILE: src/instance_table_weighted_selector_assert.svh
// Assertion macros for the instance table weighted selector.
// Used by the top level; needs aclk and aresetn in scope.
`ifndef INSTANCE_TABLE_WEIGHTED_SELECTOR_ASSERT_SVH
`define INSTANCE_TABLE_WEIGHTED_SELECTOR_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define ISW_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// antecedent implies consequent in the next cycle
`define ISW_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: src/isw_pkg.sv
// Package for the instance table weighted selector: beat types, codes, states.
// No dependencies.
package isw_pkg;

    localparam logic [2:0] ACT_ADD       = 3'd0;
    localparam logic [2:0] ACT_REMOVE    = 3'd1;
    localparam logic [2:0] ACT_HEARTBEAT = 3'd2;
    localparam logic [2:0] ACT_HEALTH    = 3'd3;
    localparam logic [2:0] ACT_SELECT    = 3'd4;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_MISS = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;

    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_DEFAULT_WEIGHT  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEALTH_INTERVAL = 2'd1;

    localparam logic [15:0] DEFAULT_WEIGHT_RESET  = 16'd1;
    localparam logic [15:0] HEALTH_INTERVAL_RESET = 16'd10;
    localparam logic [8:0]  UNHEALTHY_MAX         = 9'd511;

    typedef struct packed {
        logic [2:0]  action;
        logic [3:0]  service_slot;
        logic [31:0] host_key;
        logic [15:0] port_number;
        logic [15:0] weight_in;
        logic [31:0] now_seconds;
        logic [30:0] random_value;
    } in_beat_t;

    typedef struct packed {
        logic [1:0] status;
        logic [3:0] instance_index;
        logic [8:0] stale_count;
    } out_beat_t;

    typedef struct packed {
        logic [31:0] host;
        logic [15:0] port;
        logic [15:0] weight;
        logic        healthy;
        logic [31:0] heartbeat;
    } entry_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ADD,
        S_FIND_RD,
        S_FIND_CHK,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_HC_RD,
        S_HC_CHK,
        S_SUM_RD,
        S_SUM_CHK,
        S_MOD_WAIT,
        S_PICK_RD,
        S_PICK_CHK,
        S_DONE
    } state_t;

endpackage

FILE: src/isw_ram.sv
// Generic single write port, single read port RAM with registered read.
// No dependencies.
module isw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

FILE: src/isw_mod.sv
// Bit-serial restoring remainder unit: 31-bit dividend modulo 32-bit divisor.
// No dependencies; one quotient bit per cycle.
module isw_mod (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [30:0] dividend,
    input  logic [31:0] divisor,
    output logic        done,
    output logic [31:0] remainder
);
    logic        busy_reg, busy_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic [30:0] dvd_reg, dvd_next;
    logic [31:0] div_reg, div_next;
    logic [31:0] rem_reg, rem_next;
    logic [32:0] trial;
    logic        done_reg, done_next;

    always_comb begin
        trial     = {rem_reg, dvd_reg[30]};
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        div_next  = div_reg;
        rem_next  = rem_reg;
        done_next = 1'b0;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = 5'd0;
            dvd_next  = dividend;
            div_next  = divisor;
            rem_next  = 32'd0;
        end else if (busy_reg) begin
            if (trial >= {1'b0, div_reg}) begin
                trial = trial - {1'b0, div_reg};
            end
            rem_next = trial[31:0];
            dvd_next = {dvd_reg[29:0], 1'b0};
            cnt_next = cnt_reg + 5'd1;
            if (cnt_reg == 5'd30) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        cnt_reg <= cnt_next;
        dvd_reg <= dvd_next;
        div_reg <= div_next;
        rem_reg <= rem_next;
    end

    assign done      = done_reg;
    assign remainder = rem_reg;
endmodule

FILE: src/instance_table_weighted_selector.sv
// Top level of the instance table weighted selector.
// Depends on isw_pkg, isw_ram, isw_mod and instance_table_weighted_selector_assert.svh.
//
// One action at a time; the entries of all slots live in one RAM, and each entry
// is visited by a read state and then a check state. Add writes the new entry
// at the slot's count unless the slot is full. Remove and heartbeat scan the
// slot's entries up to the match; remove then shifts each later entry down.
// Select sums the weights of the healthy entries, then runs the bit-serial
// modulo and the draw when more than one entry is healthy and the total is
// nonzero. Health check scans every stored entry of every slot. Each result
// waits in S_DONE until the output register is free. No clearing pass: only entries below a slot's count are ever used.
module instance_table_weighted_selector #(
    parameter int SERVICE_SLOTS         = 16,
    parameter int INSTANCES_PER_SERVICE = 16
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  isw_pkg::in_beat_t                   s_data,
    output logic                                m_valid,
    input  logic                                m_ready,
    output isw_pkg::out_beat_t                  m_data,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [isw_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [15:0]                         cfg_data
);
    import isw_pkg::*;

    localparam int SLOT_W = (SERVICE_SLOTS > 1) ? $clog2(SERVICE_SLOTS) : 1;
    localparam int IDX_W  = (INSTANCES_PER_SERVICE > 1) ? $clog2(INSTANCES_PER_SERVICE) : 1;
    localparam int CNT_W  = $clog2(INSTANCES_PER_SERVICE + 1);
    localparam int ADDR_W = SLOT_W + IDX_W;
    localparam int DEPTH  = 1 << ADDR_W;
    localparam logic [CNT_W-1:0]  INST_MAX  = CNT_W'(INSTANCES_PER_SERVICE);
    localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(SERVICE_SLOTS - 1);
    localparam logic [8:0]        SLOTS_9   = 9'(SERVICE_SLOTS);

    state_t state_reg, state_next;

    in_beat_t         in_reg, in_next;
    logic [CNT_W-1:0] j_reg, j_next;
    logic [SLOT_W-1:0] slot_reg, slot_next;
    logic [1:0]       status_reg, status_next;
    logic [3:0]       idx_reg, idx_next;
    logic [8:0]       unh_reg, unh_next;
    logic [1:0]       hcnt_reg, hcnt_next;
    logic [CNT_W-1:0] last_reg, last_next;
    logic [31:0]      total_reg, total_next;
    logic [31:0]      acc_reg, acc_next;
    logic [31:0]      pick_reg, pick_next;
    logic             m_valid_reg, m_valid_next;
    out_beat_t        m_data_reg, m_data_next;
    logic [15:0]      dweight_reg, hint_reg;

    logic [CNT_W-1:0] count_reg [SERVICE_SLOTS];
    logic             cnt_we;
    logic [CNT_W-1:0] cnt_val;

    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr, ram_raddr;
    entry_t            ram_wdata, ram_rdata;

    logic              mod_start, mod_done;
    logic [31:0]       mod_rem;

    logic [CNT_W-1:0]  cur_n;
    logic [CNT_W:0]    j_plus;
    logic              in_slot_ok, match, stale, out_free;
    logic [31:0]       diff, acc_sum;
    logic [17:0]       thr;

    isw_ram #(.WIDTH($bits(entry_t)), .DEPTH(DEPTH)) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    isw_mod u_mod (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (mod_start),
        .dividend  (in_reg.random_value),
        .divisor   (total_reg),
        .done      (mod_done),
        .remainder (mod_rem)
    );

    always_comb begin
        cur_n      = count_reg[slot_reg];
        j_plus     = {1'b0, j_reg} + {{CNT_W{1'b0}}, 1'b1};
        in_slot_ok = {5'd0, s_data.service_slot} < SLOTS_9;
        match      = (ram_rdata.host == in_reg.host_key) && (ram_rdata.port == in_reg.port_number);
        diff       = in_reg.now_seconds - ram_rdata.heartbeat;
        thr        = {1'b0, hint_reg, 1'b0} + {2'b00, hint_reg};
        stale      = !diff[31] && (diff > {14'd0, thr});
        acc_sum    = acc_reg + {16'd0, ram_rdata.weight};
        out_free   = !m_valid_reg || m_ready;
        ram_raddr  = {slot_reg, (state_reg == S_SHIFT_RD) ? j_plus[IDX_W-1:0] : j_reg[IDX_W-1:0]};
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    if (s_data.action == ACT_HEALTH) begin
                        state_next = S_HC_RD;
                    end else if (!in_slot_ok || s_data.action > ACT_SELECT) begin
                        state_next = S_DONE;
                    end else if (s_data.action == ACT_ADD) begin
                        state_next = S_ADD;
                    end else if (s_data.action == ACT_SELECT) begin
                        state_next = S_SUM_RD;
                    end else begin
                        state_next = S_FIND_RD;
                    end
                end
            end
            S_ADD:      state_next = S_DONE;
            S_FIND_RD:  state_next = (j_reg == cur_n) ? S_DONE : S_FIND_CHK;
            S_FIND_CHK: begin
                if (!match) begin
                    state_next = S_FIND_RD;
                end else if (in_reg.action == ACT_REMOVE) begin
                    state_next = S_SHIFT_RD;
                end else begin
                    state_next = S_DONE;
                end
            end
            S_SHIFT_RD: state_next = (j_plus >= {1'b0, cur_n}) ? S_DONE : S_SHIFT_WR;
            S_SHIFT_WR: state_next = S_SHIFT_RD;
            S_HC_RD: begin
                if (j_reg < cur_n) begin
                    state_next = S_HC_CHK;
                end else if (slot_reg == SLOT_LAST) begin
                    state_next = S_DONE;
                end
            end
            S_HC_CHK:   state_next = S_HC_RD;
            S_SUM_RD: begin
                if (j_reg != cur_n) begin
                    state_next = S_SUM_CHK;
                end else if (hcnt_reg == 2'd2 && total_reg != 32'd0) begin
                    state_next = S_MOD_WAIT;
                end else begin
                    state_next = S_DONE;
                end
            end
            S_SUM_CHK:  state_next = S_SUM_RD;
            S_MOD_WAIT: state_next = mod_done ? S_PICK_RD : S_MOD_WAIT;
            S_PICK_RD:  state_next = (j_reg == cur_n) ? S_DONE : S_PICK_CHK;
            S_PICK_CHK: begin
                if (ram_rdata.healthy && pick_reg < acc_sum) begin
                    state_next = S_DONE;
                end else begin
                    state_next = S_PICK_RD;
                end
            end
            S_DONE:     state_next = out_free ? S_IDLE : S_DONE;
            default:    state_next = S_IDLE;
        endcase
    end

    // outputs and datapath
    always_comb begin
        in_next      = in_reg;
        j_next       = j_reg;
        slot_next    = slot_reg;
        status_next  = status_reg;
        idx_next     = idx_reg;
        unh_next     = unh_reg;
        hcnt_next    = hcnt_reg;
        last_next    = last_reg;
        total_next   = total_reg;
        acc_next     = acc_reg;
        pick_next    = pick_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_data_next  = m_data_reg;
        cnt_we       = 1'b0;
        cnt_val      = cur_n;
        ram_we       = 1'b0;
        ram_waddr    = {slot_reg, j_reg[IDX_W-1:0]};
        ram_wdata    = ram_rdata;
        mod_start    = 1'b0;
        s_ready      = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    in_next     = s_data;
                    j_next      = '0;
                    slot_next   = (s_data.action == ACT_HEALTH) ? '0 : SLOT_W'(s_data.service_slot);
                    status_next = ST_MISS;
                    idx_next    = 4'd0;
                    unh_next    = 9'd0;
                    hcnt_next   = 2'd0;
                    last_next   = '0;
                    total_next  = 32'd0;
                    acc_next    = 32'd0;
                end
            end
            S_ADD: begin
                if (cur_n >= INST_MAX) begin
                    status_next = ST_FULL;
                end else begin
                    ram_we           = 1'b1;
                    ram_waddr        = {slot_reg, cur_n[IDX_W-1:0]};
                    ram_wdata.host   = in_reg.host_key;
                    ram_wdata.port   = in_reg.port_number;
                    ram_wdata.weight = (in_reg.weight_in != 16'd0) ? in_reg.weight_in
                                                                  : dweight_reg;
                    ram_wdata.healthy   = 1'b1;
                    ram_wdata.heartbeat = in_reg.now_seconds;
                    cnt_we      = 1'b1;
                    cnt_val     = cur_n + CNT_W'(1);
                    status_next = ST_OK;
                    idx_next    = 4'(cur_n);
                end
            end
            S_FIND_RD: ;
            S_FIND_CHK: begin
                if (match) begin
                    if (in_reg.action == ACT_HEARTBEAT) begin
                        ram_we              = 1'b1;
                        ram_wdata.heartbeat = in_reg.now_seconds;
                        ram_wdata.healthy   = 1'b1;
                        status_next         = ST_OK;
                    end
                end else begin
                    j_next = j_plus[CNT_W-1:0];
                end
            end
            S_SHIFT_RD: begin
                if (j_plus >= {1'b0, cur_n}) begin
                    cnt_we      = 1'b1;
                    cnt_val     = cur_n - CNT_W'(1);
                    status_next = ST_OK;
                end
            end
            S_SHIFT_WR: begin
                ram_we = 1'b1;
                j_next = j_plus[CNT_W-1:0];
            end
            S_HC_RD: begin
                if (j_reg >= cur_n) begin
                    if (slot_reg == SLOT_LAST) begin
                        status_next = ST_OK;
                    end else begin
                        slot_next = slot_reg + SLOT_W'(1);
                        j_next    = '0;
                    end
                end
            end
            S_HC_CHK: begin
                if (ram_rdata.healthy && stale) begin
                    ram_we            = 1'b1;
                    ram_wdata.healthy = 1'b0;
                    if (unh_reg != UNHEALTHY_MAX) begin
                        unh_next = unh_reg + 9'd1;
                    end
                end
                j_next = j_plus[CNT_W-1:0];
            end
            S_SUM_RD: begin
                if (j_reg == cur_n) begin
                    if (hcnt_reg == 2'd1) begin
                        status_next = ST_OK;
                        idx_next    = 4'(last_reg);
                    end else if (hcnt_reg == 2'd2 && total_reg != 32'd0) begin
                        mod_start = 1'b1;
                    end
                end
            end
            S_SUM_CHK: begin
                if (ram_rdata.healthy) begin
                    if (hcnt_reg != 2'd2) begin
                        hcnt_next = hcnt_reg + 2'd1;
                    end
                    last_next  = j_reg;
                    total_next = total_reg + {16'd0, ram_rdata.weight};
                end
                j_next = j_plus[CNT_W-1:0];
            end
            S_MOD_WAIT: begin
                if (mod_done) begin
                    pick_next = mod_rem;
                    j_next    = '0;
                    acc_next  = 32'd0;
                end
            end
            S_PICK_RD: ;
            S_PICK_CHK: begin
                if (ram_rdata.healthy) begin
                    acc_next = acc_sum;
                    if (pick_reg < acc_sum) begin
                        status_next = ST_OK;
                        idx_next    = 4'(j_reg);
                    end
                end
                j_next = j_plus[CNT_W-1:0];
            end
            S_DONE: begin
                if (out_free) begin
                    m_valid_next               = 1'b1;
                    m_data_next.status         = status_reg;
                    m_data_next.instance_index = (status_reg == ST_OK) ? idx_reg : 4'd0;
                    m_data_next.stale_count    = unh_reg;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
            slot_reg    <= '0;
            dweight_reg <= DEFAULT_WEIGHT_RESET;
            hint_reg    <= HEALTH_INTERVAL_RESET;
            for (int k = 0; k < SERVICE_SLOTS; k++) begin
                count_reg[k] <= '0;
            end
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            slot_reg    <= slot_next;
            if (cnt_we) begin
                count_reg[slot_reg] <= cnt_val;
            end
            if (cfg_valid) begin
                if (cfg_index == CFG_DEFAULT_WEIGHT) begin
                    dweight_reg <= cfg_data;
                end
                if (cfg_index == CFG_HEALTH_INTERVAL) begin
                    hint_reg <= cfg_data;
                end
            end
        end
        in_reg     <= in_next;
        j_reg      <= j_next;
        status_reg <= status_next;
        idx_reg    <= idx_next;
        unh_reg    <= unh_next;
        hcnt_reg   <= hcnt_next;
        last_reg   <= last_next;
        total_reg  <= total_next;
        acc_reg    <= acc_next;
        pick_reg   <= pick_next;
        m_data_reg <= m_data_next;
    end

    assign cfg_ready = 1'b1;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;

    `include "instance_table_weighted_selector_assert.svh"

    `ISW_ASSERT_NOW(a_count_bound, 1'b1, cur_n <= INST_MAX, "slot count above capacity")
    `ISW_ASSERT_NEXT(a_done_loads, state_reg == S_DONE && out_free, m_valid_reg, "result lost")
    `ISW_ASSERT_NOW(a_mod_state, mod_done, state_reg == S_MOD_WAIT, "modulo done out of place")
    `ISW_ASSERT_NOW(a_we_state, ram_we, state_reg == S_ADD || state_reg == S_FIND_CHK || state_reg == S_SHIFT_WR || state_reg == S_HC_CHK, "stray RAM write")
endmodule

FILE: verif/instance_table_weighted_selector_tb.sv
// Self-checking testbench for instance_table_weighted_selector: random and directed
// table actions under handshake gaps, checked against an in-bench table predictor.
// Depends on isw_pkg and the RTL of the block.
`timescale 1ns / 100ps

module instance_table_weighted_selector_tb;
    import isw_pkg::*;

    localparam int          SLOTS         = 16;
    localparam int          DEPTH         = 16;
    localparam logic [2:0]  ACT_BAD_FIRST = 3'd5;
    localparam logic [2:0]  ACT_BAD_LAST  = 3'd7;

    logic      aclk = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_beat_t  s_data = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_beat_t m_data;
    logic      cfg_valid = 1'b0;
    logic      cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [15:0] cfg_data = '0;

    instance_table_weighted_selector dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always #1 aclk = ~aclk;

    // table shadow
    int          slot_count [SLOTS];
    entry_t      tbl [SLOTS][DEPTH];
    logic [15:0] dflt_weight = DEFAULT_WEIGHT_RESET;
    logic [15:0] interval    = HEALTH_INTERVAL_RESET;

    in_beat_t  action_q[$];
    out_beat_t outcome_q[$];
    int        fail_count = 0;
    int        results_seen = 0;
    bit        calm = 1'b0;
    logic [31:0] gen_now = 32'd100;

    function automatic int find_entry(int s, logic [31:0] host, logic [15:0] port);
        for (int i = 0; i < slot_count[s]; i++)
            if (tbl[s][i].host == host && tbl[s][i].port == port) return i;
        return -1;
    endfunction

    function automatic bit is_stale(logic [31:0] now, logic [31:0] hb);
        logic [31:0] diff;
        diff = now - hb;
        if (diff[31]) return 1'b0;
        return diff > 32'd3 * {16'd0, interval};
    endfunction

    function automatic out_beat_t apply_action(in_beat_t b);
        out_beat_t   r;
        int          s, n, m, healthy, last;
        logic [31:0] total, acc, pick;
        r = '0;
        r.status = ST_MISS;
        s = b.service_slot;
        n = slot_count[s];
        if (b.action == ACT_HEALTH) begin
            for (int i = 0; i < SLOTS; i++)
                for (int j = 0; j < slot_count[i]; j++)
                    if (tbl[i][j].healthy && is_stale(b.now_seconds, tbl[i][j].heartbeat)) begin
                        tbl[i][j].healthy = 1'b0;
                        if (r.stale_count < UNHEALTHY_MAX) r.stale_count++;
                    end
            r.status = ST_OK;
        end else if (b.action == ACT_ADD) begin
            if (n >= DEPTH) begin
                r.status = ST_FULL;
            end else begin
                tbl[s][n].host = b.host_key;
                tbl[s][n].port = b.port_number;
                tbl[s][n].weight = (b.weight_in != 0) ? b.weight_in : dflt_weight;
                tbl[s][n].healthy = 1'b1;
                tbl[s][n].heartbeat = b.now_seconds;
                slot_count[s] = n + 1;
                r.status = ST_OK;
                r.instance_index = 4'(n);
            end
        end else if (b.action == ACT_REMOVE) begin
            m = find_entry(s, b.host_key, b.port_number);
            if (m >= 0) begin
                for (int j = m; j + 1 < n; j++) tbl[s][j] = tbl[s][j + 1];
                slot_count[s] = n - 1;
                r.status = ST_OK;
            end
        end else if (b.action == ACT_HEARTBEAT) begin
            m = find_entry(s, b.host_key, b.port_number);
            if (m >= 0) begin
                tbl[s][m].heartbeat = b.now_seconds;
                tbl[s][m].healthy = 1'b1;
                r.status = ST_OK;
            end
        end else if (b.action == ACT_SELECT) begin
            healthy = 0; last = 0; total = 0; acc = 0;
            for (int j = 0; j < n; j++)
                if (tbl[s][j].healthy) begin
                    healthy++;
                    last = j;
                    total += tbl[s][j].weight;
                end
            if (healthy == 1) begin
                r.status = ST_OK;
                r.instance_index = 4'(last);
            end else if (healthy > 1 && total > 0) begin
                pick = {1'b0, b.random_value} % total;
                for (int j = 0; j < n; j++) begin
                    if (!tbl[s][j].healthy) continue;
                    acc += tbl[s][j].weight;
                    if (pick < acc) begin
                        r.status = ST_OK;
                        r.instance_index = 4'(j);
                        break;
                    end
                end
            end
        end
        return r;
    endfunction

    // driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) outcome_q.push_back(apply_action(s_data));
            if (!s_valid || s_ready) begin
                if (action_q.size() > 0 && (calm || $urandom_range(0, 99) >= 36)) begin
                    s_valid <= 1'b1;
                    s_data <= action_q.pop_front();
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // monitor; one long hold-off to back the block up
    int hold_left = 0;
    bit held = 1'b0;
    always @(posedge aclk) begin
        out_beat_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                results_seen++;
                if (outcome_q.size() == 0) begin
                    $error("unexpected beat: status %0d", m_data.status);
                    fail_count++;
                end else begin
                    want = outcome_q.pop_front();
                    if (m_data.status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, m_data.status);
                        fail_count++;
                    end
                    if (m_data.instance_index !== want.instance_index) begin
                        $error("instance_index: expected %0d, got %0d",
                               want.instance_index, m_data.instance_index);
                        fail_count++;
                    end
                    if (m_data.stale_count !== want.stale_count) begin
                        $error("stale_count: expected %0d, got %0d",
                               want.stale_count, m_data.stale_count);
                        fail_count++;
                    end
                end
            end
            if (!held && results_seen >= 200) begin
                held = 1'b1;
                hold_left = 400;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= calm || $urandom_range(0, 99) >= 36;
            end
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge aclk); while (!(cfg_valid && cfg_ready));
        cfg_valid <= 1'b0;
        if (idx == CFG_DEFAULT_WEIGHT) dflt_weight = val;
        else interval = val;
    endtask

    task automatic drain();
        while (action_q.size() > 0 || s_valid || outcome_q.size() > 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic push_action(input logic [2:0] act, input int s, input logic [31:0] host,
                               input logic [15:0] port, input logic [15:0] w,
                               input logic [31:0] now, input logic [30:0] rnd);
        in_beat_t b;
        b.action = act; b.service_slot = 4'(s); b.host_key = host; b.port_number = port;
        b.weight_in = w; b.now_seconds = now; b.random_value = rnd;
        action_q.push_back(b);
    endtask

    task automatic push_random(input int count);
        logic [31:0] hosts [4];
        logic [15:0] ports [4];
        logic [2:0]  act;
        logic [31:0] host;
        logic [15:0] port, w;
        int          pct, s;
        hosts = '{32'h0, 32'hFFFF_FFFF, 32'h1234_5678, 32'h8000_0001};
        ports = '{16'h0, 16'hFFFF, 16'd80, 16'd443};
        repeat (count) begin
            pct = $urandom_range(0, 99);
            if (pct < 35) act = ACT_ADD;
            else if (pct < 50) act = ACT_REMOVE;
            else if (pct < 70) act = ACT_HEARTBEAT;
            else if (pct < 78) act = ACT_HEALTH;
            else if (pct < 98) act = ACT_SELECT;
            else act = 3'($urandom_range(ACT_BAD_FIRST, ACT_BAD_LAST));
            s = ($urandom_range(0, 9) < 7) ? $urandom_range(0, 2) : $urandom_range(0, SLOTS - 1);
            host = ($urandom_range(0, 9) == 0) ? $urandom : hosts[$urandom_range(0, 3)];
            port = ($urandom_range(0, 9) == 0) ? 16'($urandom) : ports[$urandom_range(0, 3)];
            pct = $urandom_range(0, 99);
            if (pct < 20) w = 16'd0;
            else if (pct < 30) w = 16'hFFFF;
            else if (pct < 35) w = 16'($urandom);
            else w = 16'($urandom_range(1, 100));
            if ($urandom_range(0, 32) == 0) gen_now = $urandom;
            else gen_now += $urandom_range(0, 15);
            push_action(act, s, host, port, w, gen_now, 31'($urandom));
        end
    endtask

    initial begin
        foreach (slot_count[i]) slot_count[i] = 0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // directed
        push_action(ACT_SELECT, 1, 0, 0, 0, 100, 0);
        push_action(ACT_ADD, 1, 32'hFFFF_FFFF, 16'hFFFF, 16'd0, 100, 0);
        push_action(ACT_SELECT, 1, 0, 0, 0, 100, 31'h7FFF_FFFF);
        push_action(ACT_ADD, 1, 32'h0, 16'h0, 16'hFFFF, 100, 0);
        push_action(ACT_ADD, 1, 32'h5, 16'd7, 16'd1, 100, 0);
        push_action(ACT_ADD, 1, 32'h5, 16'd7, 16'd3, 100, 0);
        push_action(ACT_SELECT, 1, 0, 0, 0, 100, 31'h7FFF_FFFF);
        push_action(ACT_SELECT, 1, 0, 0, 0, 100, 31'd65535);
        push_action(ACT_HEARTBEAT, 1, 32'h6, 16'd7, 0, 110, 0);
        push_action(ACT_HEARTBEAT, 1, 32'h5, 16'd7, 0, 125, 0);
        push_action(ACT_REMOVE, 1, 32'h5, 16'd7, 0, 0, 0);
        push_action(ACT_REMOVE, 1, 32'h5, 16'd8, 0, 0, 0);
        push_action(ACT_HEALTH, 9, 0, 0, 0, 50, 0);
        push_action(ACT_HEALTH, 0, 0, 0, 0, 130, 0);
        push_action(ACT_HEALTH, 0, 0, 0, 0, 131, 0);
        push_action(ACT_SELECT, 1, 0, 0, 0, 131, 0);
        push_action(ACT_HEARTBEAT, 1, 32'h0, 16'h0, 0, 140, 0);
        push_action(ACT_SELECT, 1, 0, 0, 0, 140, 31'h1234);
        push_action(ACT_ADD, 15, 32'h9, 16'd9, 0, 140, 0);
        push_action(ACT_SELECT, 15, 0, 0, 0, 140, 0);
        push_action(ACT_BAD_FIRST, 1, 0, 0, 0, 0, 0);
        push_action(ACT_BAD_LAST, 1, 0, 0, 0, 0, 0);
        push_action(ACT_HEALTH, 0, 0, 0, 0, 32'hFFFF_FFFF, 0);
        drain();

        // settings: zero, wide, tight, back to reset values
        write_reg(CFG_DEFAULT_WEIGHT, 16'd0);
        write_reg(CFG_HEALTH_INTERVAL, 16'd0);
        push_random(250);
        drain();
        write_reg(CFG_DEFAULT_WEIGHT, 16'hFFFF);
        write_reg(CFG_HEALTH_INTERVAL, 16'hFFFF);
        push_random(250);
        drain();
        calm = 1'b1;
        write_reg(CFG_DEFAULT_WEIGHT, 16'd7);
        write_reg(CFG_HEALTH_INTERVAL, 16'd1);
        push_random(200);
        drain();
        calm = 1'b0;
        write_reg(CFG_DEFAULT_WEIGHT, DEFAULT_WEIGHT_RESET);
        write_reg(CFG_HEALTH_INTERVAL, HEALTH_INTERVAL_RESET);
        push_random(530);
        drain();
        repeat (20) @(posedge aclk);

        if (fail_count == 0) begin
            $display("instance_table_weighted_selector_tb passed");
        end else begin
            $display("instance_table_weighted_selector_tb failed");
        end
        $finish;
    end

    initial begin
        #10ms;
        $display("instance_table_weighted_selector_tb failed");
        $finish;
    end

endmodule

FILE: sim.f
+incdir+src
src/isw_pkg.sv
src/isw_ram.sv
src/isw_mod.sv
src/instance_table_weighted_selector.sv
verif/instance_table_weighted_selector_tb.sv
